@@ hw/rtl/pfa_pkg.sv @@
package pfa_pkg;

    localparam int WORD_BITS        = 32;
    localparam int MAX_WORDS_DEF    = 1024;
    localparam int INDEX_BITS       = 16;
    localparam int WIDTH_REG_BITS   = 6;
    localparam int COUNT_REG_BITS   = 16;
    localparam int CFG_DATA_BITS    = 16;
    localparam int RECIP_BITS       = 18;
    localparam int RECIP_SHIFT      = 17;
    localparam int SLOT_BITS        = 5;
    localparam int PER_WORD_BITS    = 6;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_RANGE     = 2'd1;
    localparam logic [1:0] STATUS_TOO_LARGE = 2'd2;

    localparam logic REG_VALUE_WIDTH   = 1'b0;
    localparam logic REG_ELEMENT_COUNT = 1'b1;

    // fields per word for a field width of 1..32
    function automatic logic [PER_WORD_BITS-1:0] per_word(input logic [WIDTH_REG_BITS-1:0] w);
        logic [PER_WORD_BITS-1:0] f;
        case (w) inside
            6'd1:       f = 6'd32;
            6'd2:       f = 6'd16;
            6'd3:       f = 6'd10;
            6'd4:       f = 6'd8;
            6'd5:       f = 6'd6;
            6'd6:       f = 6'd5;
            [6'd7:6'd8]:   f = 6'd4;
            [6'd9:6'd10]:  f = 6'd3;
            [6'd11:6'd16]: f = 6'd2;
            default:    f = 6'd1;
        endcase
        return f;
    endfunction

    // floor(2^17 / fields per word); quotient estimate is low by at most one
    function automatic logic [RECIP_BITS-1:0] recip(input logic [WIDTH_REG_BITS-1:0] w);
        logic [RECIP_BITS-1:0] m;
        case (w) inside
            6'd1:       m = 18'd4096;
            6'd2:       m = 18'd8192;
            6'd3:       m = 18'd13107;
            6'd4:       m = 18'd16384;
            6'd5:       m = 18'd21845;
            6'd6:       m = 18'd26214;
            [6'd7:6'd8]:   m = 18'd32768;
            [6'd9:6'd10]:  m = 18'd43690;
            [6'd11:6'd16]: m = 18'd65536;
            default:    m = 18'd131072;
        endcase
        return m;
    endfunction

endpackage

@@ hw/rtl/pfa_in_if.sv @@
interface pfa_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] index;
    logic [31:0] write_value;

    modport source (output valid, cmd, index, write_value, input ready);
    modport sink   (input valid, cmd, index, write_value, output ready);
endinterface

@@ hw/rtl/pfa_out_if.sv @@
interface pfa_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_value;
    logic [1:0]  status;

    modport source (output valid, read_value, status, input ready);
    modport sink   (input valid, read_value, status, output ready);
endinterface

@@ hw/rtl/pfa_store.sv @@
module pfa_store #(
    parameter int MAX_WORDS = pfa_pkg::MAX_WORDS_DEF,
    parameter int AW        = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          we,
    input  logic [AW-1:0]                 addr,
    input  logic [pfa_pkg::WORD_BITS-1:0] wdata,
    output logic [pfa_pkg::WORD_BITS-1:0] rdata,
    output logic                          busy
);

    logic [pfa_pkg::WORD_BITS-1:0] mem [MAX_WORDS];
    logic [pfa_pkg::WORD_BITS-1:0] rdata_reg;
    logic                          clr_active_reg;
    logic [AW-1:0]                 clr_addr_reg;

    logic                          m_we;
    logic                          m_re;
    logic [AW-1:0]                 m_addr;
    logic [pfa_pkg::WORD_BITS-1:0] m_wdata;

    always_comb
    begin
        if (clr_active_reg)
        begin
            m_we    = 1'b1;
            m_re    = 1'b0;
            m_addr  = clr_addr_reg;
            m_wdata = '0;
        end
        else
        begin
            m_we    = en & we;
            m_re    = en & ~we;
            m_addr  = addr;
            m_wdata = wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_we)
        begin
            mem[m_addr] <= m_wdata;
        end
        if (m_re)
        begin
            rdata_reg <= mem[m_addr];
        end
    end

    // zero sweep after reset, one word a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_addr_reg == AW'(MAX_WORDS - 1))
            begin
                clr_active_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    assign rdata = rdata_reg;
    assign busy  = clr_active_reg;

endmodule

@@ hw/rtl/packed_field_array_top.sv @@
// Packed field array: values of value_width bits (1..32) packed into 32-bit
// words held in one single-port RAM of MAX_WORDS words, first element in the
// most significant field of a word. After reset the RAM is zeroed by a sweep
// of all MAX_WORDS words during which req is not ready; configuration writes are
// taken at any time but must only be issued while no word is in flight. Each
// request word passes from acceptance to a response on rsp through a
// reciprocal multiply for the word index, a remainder correction and range
// check, the RAM read, then the field extract or read-modify-write. One
// request is in flight at a time, so the next is accepted only once the last
// has left S_MOD; the registered response lets the next request be accepted
// while a response still waits on rsp.
module packed_field_array_top #(
    parameter int MAX_WORDS = pfa_pkg::MAX_WORDS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [pfa_pkg::CFG_DATA_BITS-1:0] cfg_data,
    pfa_in_if.sink                            req,
    pfa_out_if.source                         rsp
);

    localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CHK,
        S_RD,
        S_MOD
    } state_t;

    state_t state_reg;

    logic [pfa_pkg::WIDTH_REG_BITS-1:0] width_cfg_reg;
    logic [pfa_pkg::COUNT_REG_BITS-1:0] count_cfg_reg;

    logic                               cmd_reg;
    logic [pfa_pkg::INDEX_BITS-1:0]     idx_reg;
    logic [pfa_pkg::WORD_BITS-1:0]      wval_reg;
    logic [pfa_pkg::INDEX_BITS-1:0]     qest_reg;
    logic [pfa_pkg::INDEX_BITS-1:0]     q_reg;
    logic [pfa_pkg::SLOT_BITS-1:0]      slot_reg;
    logic [1:0]                         st_reg;
    logic [pfa_pkg::SLOT_BITS-1:0]      gap_reg;
    logic                               out_valid_reg;
    logic [pfa_pkg::WORD_BITS-1:0]      rv_reg;
    logic [1:0]                         st_out_reg;

    logic [pfa_pkg::WIDTH_REG_BITS-1:0] w_eff;
    logic [pfa_pkg::PER_WORD_BITS-1:0]  f;
    logic [pfa_pkg::WORD_BITS-1:0]      fmask;
    logic [33:0]                        div_prod;
    logic [21:0]                        qf_full;
    logic [16:0]                        qf;
    logic [16:0]                        rem;
    logic                               corr;
    logic [pfa_pkg::INDEX_BITS-1:0]     q_next;
    logic [pfa_pkg::SLOT_BITS-1:0]      slot_next;
    logic [16:0]                        qf_fix;
    logic                               range_bad;
    logic                               too_large;
    logic [1:0]                         st_next;
    logic [10:0]                        gap_full;
    logic [pfa_pkg::PER_WORD_BITS-1:0]  fields_after;

    logic                               mem_en;
    logic                               mem_we;
    logic [pfa_pkg::WORD_BITS-1:0]      mem_wdata;
    logic [pfa_pkg::WORD_BITS-1:0]      mem_rdata;
    logic                               mem_busy;
    logic [pfa_pkg::WORD_BITS-1:0]      field_mask;
    logic [pfa_pkg::WORD_BITS-1:0]      rv_next;
    logic                               advance;

    always_comb
    begin
        if (width_cfg_reg == '0)
            w_eff = 6'd1;
        else if (width_cfg_reg > 6'd32)
            w_eff = 6'd32;
        else
            w_eff = width_cfg_reg;
    end

    assign f     = pfa_pkg::per_word(w_eff);
    assign fmask = {pfa_pkg::WORD_BITS{1'b1}} >> (6'd32 - w_eff);

    // word index estimate
    assign div_prod = 34'(idx_reg) * 34'(pfa_pkg::recip(w_eff));

    // remainder and one-step correction
    assign qf_full   = 22'(qest_reg) * 22'(f);
    assign qf        = qf_full[16:0];
    assign rem       = {1'b0, idx_reg} - qf;
    assign corr      = rem >= 17'(f);
    assign q_next    = qest_reg + 16'(corr);
    assign slot_next = corr ? 5'(rem - 17'(f)) : rem[4:0];
    assign qf_fix    = corr ? qf + 17'(f) : qf;
    // word past words in use  <=>  word * F >= element_count; also out of range if word >= MAX_WORDS
    assign range_bad = (qf_fix >= {1'b0, count_cfg_reg})
                    || ({1'b0, q_next} >= 17'(MAX_WORDS));
    assign too_large = (cmd_reg == pfa_pkg::CMD_WRITE) && ((wval_reg & ~fmask) != '0);

    always_comb
    begin
        if (too_large)
            st_next = pfa_pkg::STATUS_TOO_LARGE;
        else if (range_bad)
            st_next = pfa_pkg::STATUS_RANGE;
        else
            st_next = pfa_pkg::STATUS_OK;
    end

    // bit offset of the slot: (F - 1 - slot) * w
    assign fields_after = f - 6'd1 - 6'(slot_reg);
    assign gap_full     = 11'(fields_after) * 11'(w_eff);

    assign field_mask = fmask << gap_reg;
    assign rv_next    = (mem_rdata >> gap_reg) & fmask;
    assign mem_wdata  = (mem_rdata & ~field_mask) | ((wval_reg & fmask) << gap_reg);

    assign advance = !out_valid_reg || rsp.ready;

    always_comb
    begin
        mem_en = 1'b0;
        mem_we = 1'b0;
        if (state_reg == S_RD && st_reg == pfa_pkg::STATUS_OK)
        begin
            mem_en = 1'b1;
        end
        else if (state_reg == S_MOD && advance && st_reg == pfa_pkg::STATUS_OK
                 && cmd_reg == pfa_pkg::CMD_WRITE)
        begin
            mem_en = 1'b1;
            mem_we = 1'b1;
        end
    end

    pfa_store #(
        .MAX_WORDS (MAX_WORDS),
        .AW        (AW)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (q_reg[AW-1:0]),
        .wdata (mem_wdata),
        .rdata (mem_rdata),
        .busy  (mem_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg <= 6'd2;
            count_cfg_reg <= 16'd32768;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pfa_pkg::REG_VALUE_WIDTH:   width_cfg_reg <= cfg_data[5:0];
                pfa_pkg::REG_ELEMENT_COUNT: count_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_MOD && advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && !mem_busy)
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    state_reg <= S_RD;
                end
                S_RD:
                begin
                    state_reg <= S_MOD;
                end
                S_MOD:
                begin
                    if (advance)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req.valid && !mem_busy)
        begin
            cmd_reg  <= req.cmd;
            idx_reg  <= req.index;
            wval_reg <= req.write_value;
        end
        if (state_reg == S_DIV)
        begin
            qest_reg <= div_prod[32:17];
        end
        if (state_reg == S_CHK)
        begin
            q_reg    <= q_next;
            slot_reg <= slot_next;
            st_reg   <= st_next;
        end
        if (state_reg == S_RD)
        begin
            gap_reg <= gap_full[4:0];
        end
        if (state_reg == S_MOD && advance)
        begin
            st_out_reg <= st_reg;
            if (st_reg == pfa_pkg::STATUS_OK && cmd_reg == pfa_pkg::CMD_READ)
                rv_reg <= rv_next;
            else
                rv_reg <= '0;
        end
    end

    assign req.ready      = (state_reg == S_IDLE) && !mem_busy;
    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = rv_reg;
    assign rsp.status     = st_out_reg;

endmodule

@@ tb/sv/packed_field_array_top_tb.sv @@
module packed_field_array_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_WORDS    = pfa_pkg::MAX_WORDS_DEF;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PRINT_CAP    = 40;

    typedef struct packed {
        logic [31:0] read_value;
        logic [1:0]  status;
    } field_result_t;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_we;
    logic                              cfg_index;
    logic [pfa_pkg::CFG_DATA_BITS-1:0] cfg_data;

    pfa_in_if  req();
    pfa_out_if rsp();

    packed_field_array_top #(
        .MAX_WORDS (NUM_WORDS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // shadow copy of the packed store and its layout registers
    logic [31:0]   packed_store [NUM_WORDS];
    logic [5:0]    cur_width;
    logic [15:0]   cur_count;
    field_result_t results_due [$];

    int          errors       = 0;
    bit          idle_en      = 1'b1;
    int          hold_off_len = 0;
    int unsigned hot_base     = 0;

    function automatic int unsigned eff_width();
        if (cur_width == 6'd0)
            return 1;
        if (cur_width > 6'd32)
            return 32;
        return 32'(cur_width);
    endfunction

    function automatic field_result_t access_field(logic cmd, logic [15:0] idx,
                                                   logic [31:0] val);
        int unsigned   w;
        int unsigned   per_word;
        int unsigned   words_used;
        int unsigned   word;
        int unsigned   shift;
        logic [63:0]   fmask;
        logic [63:0]   m;
        logic [63:0]   cur;
        field_result_t r;
        w          = eff_width();
        per_word   = pfa_pkg::WORD_BITS / w;
        fmask      = (64'd1 << w) - 64'd1;
        words_used = (cur_count + per_word - 1) / per_word;
        word       = idx / per_word;
        // slot 0 sits in the most significant used field
        shift      = (per_word - 1 - idx % per_word) * w;
        r.read_value = '0;
        r.status     = pfa_pkg::STATUS_OK;
        if (cmd == pfa_pkg::CMD_WRITE && {32'd0, val} > fmask) begin
            r.status = pfa_pkg::STATUS_TOO_LARGE;
        end
        else if (word >= words_used || word >= NUM_WORDS) begin
            r.status = pfa_pkg::STATUS_RANGE;
        end
        else begin
            cur = {32'd0, packed_store[word]};
            m   = fmask << shift;
            if (cmd == pfa_pkg::CMD_WRITE)
                packed_store[word] = 32'((cur & ~m) | (({32'd0, val} << shift) & m));
            else
                r.read_value = 32'((cur & m) >> shift);
        end
        return r;
    endfunction

    function automatic int unsigned usable_elements();
        int unsigned per_word;
        int unsigned words;
        per_word = pfa_pkg::WORD_BITS / eff_width();
        words    = (cur_count + per_word - 1) / per_word;
        if (words > NUM_WORDS)
            words = NUM_WORDS;
        return words * per_word;
    endfunction

    function automatic logic [15:0] pick_index();
        int unsigned usable;
        logic [15:0] idx;
        usable = usable_elements();
        case ($urandom_range(0, 9))
            0, 1:    idx = 16'($urandom_range(0, 65535));
            2, 3, 4: idx = (usable > 0) ? 16'($urandom_range(0, usable - 1)) : 16'($urandom);
            default: idx = 16'(hot_base + $urandom_range(0, 47));
        endcase
        return idx;
    endfunction

    function automatic logic [31:0] pick_value();
        logic [32:0] fmask;
        logic [31:0] val;
        fmask = (33'd1 << eff_width()) - 33'd1;
        case ($urandom_range(0, 9))
            0:       val = fmask[31:0];
            1:       val = 32'(fmask + 33'd1);  // exactly 2^w below width 32, must be rejected; wraps to 0 at width 32
            2, 3:    val = $urandom;
            default: val = $urandom & fmask[31:0];
        endcase
        return val;
    endfunction

    function automatic logic [15:0] pick_count();
        logic [15:0] count;
        case ($urandom_range(0, 3))
            0:       count = 16'hFFFF;
            1:       count = 16'($urandom_range(1, 300));
            default: count = 16'($urandom_range(0, 65535));
        endcase
        return count;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (errors < PRINT_CAP)
            $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // leaves valid high after acceptance so back-to-back words need no toggle
    task automatic send_word(logic cmd, logic [15:0] idx, logic [31:0] val);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.cmd         <= cmd;
        req.index       <= idx;
        req.write_value <= val;
        do
            @(posedge clk);
        while (req.ready !== 1'b1);
    endtask

    task automatic send_random(int n);
        int unsigned usable;
        usable   = usable_elements();
        hot_base = (usable > 0) ? $urandom_range(0, usable - 1) : 0;
        repeat (n)
            send_word(($urandom_range(0, 1) == 1) ? pfa_pkg::CMD_WRITE : pfa_pkg::CMD_READ,
                      pick_index(), pick_value());
    endtask

    task automatic settle();
        req.valid <= 1'b0;
        @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic ridx, logic [15:0] data);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= ridx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (ridx == pfa_pkg::REG_VALUE_WIDTH)
            cur_width = data[5:0];
        else
            cur_count = data;
    endtask

    task automatic set_layout(logic [5:0] w, logic [15:0] count);
        write_reg(pfa_pkg::REG_VALUE_WIDTH, {10'd0, w});
        write_reg(pfa_pkg::REG_ELEMENT_COUNT, count);
    endtask

    task automatic test_directed();
        // reset layout: width 2, store limit caps the word range
        send_word(pfa_pkg::CMD_READ,  16'd0,     32'd0);
        send_word(pfa_pkg::CMD_WRITE, 16'd0,     32'd3);
        send_word(pfa_pkg::CMD_WRITE, 16'd1,     32'd4);
        send_word(pfa_pkg::CMD_READ,  16'd0,     32'd0);
        send_word(pfa_pkg::CMD_READ,  16'd1,     32'd0);
        send_word(pfa_pkg::CMD_WRITE, 16'd16383, 32'd2);
        send_word(pfa_pkg::CMD_READ,  16'd16383, 32'd0);
        send_word(pfa_pkg::CMD_READ,  16'd16384, 32'd0);
        send_word(pfa_pkg::CMD_WRITE, 16'hFFFF,  32'd7);   // size check wins over range
        send_word(pfa_pkg::CMD_WRITE, 16'hFFFF,  32'd1);
        set_layout(6'd32, 16'd1024);
        send_word(pfa_pkg::CMD_WRITE, 16'd0,     32'hFFFF_FFFF);
        send_word(pfa_pkg::CMD_READ,  16'd1023,  32'd0);
        send_word(pfa_pkg::CMD_READ,  16'd1024,  32'd0);
        // width 0 behaves as 1; count rounds up to whole words
        set_layout(6'd0, 16'd40);
        send_word(pfa_pkg::CMD_READ,  16'd1,     32'd0);
        send_word(pfa_pkg::CMD_WRITE, 16'd63,    32'd1);
        send_word(pfa_pkg::CMD_READ,  16'd64,    32'd0);
        send_word(pfa_pkg::CMD_WRITE, 16'd5,     32'd2);
        write_reg(pfa_pkg::REG_VALUE_WIDTH, 16'd63);
        send_word(pfa_pkg::CMD_READ,  16'd0,     32'd0);
        send_word(pfa_pkg::CMD_READ,  16'd1,     32'd0);
        set_layout(6'd3, 16'd0);
        send_word(pfa_pkg::CMD_READ,  16'd0,     32'd0);
        send_word(pfa_pkg::CMD_WRITE, 16'd0,     32'd7);
        write_reg(pfa_pkg::REG_ELEMENT_COUNT, 16'hFFFF);
        send_word(pfa_pkg::CMD_READ,  16'd0,     32'd0);
        send_word(pfa_pkg::CMD_WRITE, 16'd10239, 32'd5);
        send_word(pfa_pkg::CMD_READ,  16'd10240, 32'd0);
        send_word(pfa_pkg::CMD_WRITE, 16'd1,     32'd8);
    endtask

    task automatic test_layout_sweep();
        logic [5:0] w;
        for (int p = 0; p < 8; p++) begin
            case (p)
                0:       w = 6'd1;
                1:       w = 6'd32;
                2:       w = 6'd0;
                3:       w = 6'd63;
                4:       w = 6'd16;
                5:       w = 6'd33;
                default: w = 6'($urandom_range(1, 32));
            endcase
            set_layout(w, pick_count());
            idle_en = (p != 4);
            send_random(40);
        end
        idle_en = 1'b1;
    endtask

    task automatic test_backpressure();
        idle_en      = 1'b0;
        hold_off_len = 150;
        send_random(24);
        idle_en = 1'b1;
    endtask

    task automatic test_steady_stream();
        set_layout(6'($urandom_range(1, 32)), pick_count());
        idle_en = 1'b0;
        send_random(80);
    endtask

    always @(posedge clk) begin
        if (rst_n && req.valid && req.ready)
            results_due.push_back(access_field(req.cmd, req.index, req.write_value));
    end

    always @(posedge clk) begin : check_rsp
        field_result_t due;
        if (rst_n && rsp.valid && rsp.ready) begin
            if (results_due.size() == 0) begin
                report_mismatch("response with nothing due", rsp.read_value, 32'd0);
            end
            else begin
                due = results_due.pop_front();
                if (rsp.read_value !== due.read_value)
                    report_mismatch("read_value", rsp.read_value, due.read_value);
                if (rsp.status !== due.status)
                    report_mismatch("status", 32'(rsp.status), 32'(due.status));
            end
        end
    end

    initial begin
        rsp.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_off_len > 0) begin
                rsp.ready <= 1'b0;
                repeat (hold_off_len) @(posedge clk);
                hold_off_len = 0;
            end
            else if (idle_en && $urandom_range(0, 5) == 0) begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else begin
                rsp.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // covers the clearing sweep after reset as well as long receiver stalls
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= pfa_pkg::REG_VALUE_WIDTH;
        cfg_data        <= '0;
        req.valid       <= 1'b0;
        req.cmd         <= pfa_pkg::CMD_READ;
        req.index       <= '0;
        req.write_value <= '0;
        for (int i = 0; i < NUM_WORDS; i++)
            packed_store[i] = '0;
        cur_width = 6'd2;
        cur_count = 16'd32768;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_layout_sweep();
        test_backpressure();
        test_steady_stream();
        settle();

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
